// File: hdl/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants for the console line editor: byte codes,
// controller states, command and status bundles between control and datapath.
// ----------------------------------------------------------------------------
package cle_pkg;

    // Store depth default and configuration reset value
    localparam int unsigned LINE_DEPTH_DEF = 16;
    localparam int unsigned CAP_W          = 5;
    localparam int unsigned CNT_W          = 4;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Character codes
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DEL = 8'h7f;

    // Result packing widths
    localparam int unsigned RES_W   = 26;
    localparam int unsigned TDATA_W = 32;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CHAR,
        ST_NL_CR,
        ST_NL_LF,
        ST_BS1,
        ST_SP,
        ST_BS2
    } t_state;

    // Class of the held byte
    typedef enum logic [2:0] {
        K_NONE,
        K_STORE,
        K_ERASE,
        K_KILL,
        K_NEWLINE
    } t_kind;

    // Which result to form
    typedef enum logic [2:0] {
        SEL_CHAR,
        SEL_CR,
        SEL_LF,
        SEL_BS1,
        SEL_SP,
        SEL_BS2
    } t_sel;

    typedef struct packed {
        logic capture;
        logic load;
        t_sel sel;
        logic last;
    } t_cmd;

    typedef struct packed {
        t_kind            kind;
        logic             out_free;
        logic             fill_one;
        logic [CNT_W-1:0] fill;
    } t_stat;

endpackage

// File: hdl/cle_ctrl.sv
// ----------------------------------------------------------------------------
// cle_ctrl
// Controller: takes a byte, reads its class from the datapath and steps
// through the echo sequence one result per free output slot.
// ----------------------------------------------------------------------------
module cle_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  cle_pkg::t_stat i_stat,
    output cle_pkg::t_cmd  o_cmd
);
    import cle_pkg::*;

    t_state r_state, n_state;
    logic   r_kill, n_kill;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kill  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kill  <= n_kill;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_kill      = r_kill;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.sel   = SEL_CHAR;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_kill = 1'b0;
                case (i_stat.kind)
                    K_STORE:   n_state = ST_CHAR;
                    K_NEWLINE: n_state = ST_NL_CR;
                    K_ERASE:   n_state = ST_BS1;
                    K_KILL: begin
                        n_state = ST_BS1;
                        n_kill  = 1'b1;
                    end
                    default:   n_state = ST_IDLE;
                endcase
            end
            ST_CHAR: begin
                o_cmd.sel  = SEL_CHAR;
                o_cmd.last = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_NL_CR: begin
                o_cmd.sel = SEL_CR;
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_NL_LF;
                end
            end
            ST_NL_LF: begin
                o_cmd.sel  = SEL_LF;
                o_cmd.last = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_BS1: begin
                o_cmd.sel = SEL_BS1;
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SP;
                end
            end
            ST_SP: begin
                o_cmd.sel = SEL_SP;
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_BS2;
                end
            end
            ST_BS2: begin
                // Close the erase; a line kill repeats until the line is empty
                o_cmd.sel  = SEL_BS2;
                o_cmd.last = !r_kill || i_stat.fill_one;
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = o_cmd.last ? ST_IDLE : ST_BS1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: hdl/cle_datapath.sv
// ----------------------------------------------------------------------------
// cle_datapath
// Datapath: capacity register, held byte, fill count, byte classification
// and the output register that forms each result.
// ----------------------------------------------------------------------------
module cle_datapath #(
    parameter int unsigned LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cle_pkg::CAP_W-1:0]   i_cfg_data,
    input  logic [7:0]                  i_rx_byte,
    input  cle_pkg::t_cmd               i_cmd,
    output cle_pkg::t_stat              o_stat,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [cle_pkg::RES_W-1:0]   o_out_data,
    output logic                        o_out_last
);
    import cle_pkg::*;

    // Effective capacity ceiling from store depth and 4-bit count
    localparam int unsigned CAP_MAX_I = (LINE_DEPTH < 16) ? LINE_DEPTH : 16;
    localparam logic [CAP_W-1:0] CAP_MAX = CAP_MAX_I[CAP_W-1:0];

    logic [CAP_W-1:0] r_cap;
    logic [7:0]       r_rx;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             r_out_valid;
    logic [RES_W-1:0] r_out_data, n_out_data;
    logic             r_out_last;

    logic [CAP_W-1:0] w_eff_cap;
    logic [CAP_W-1:0] w_fill_inc;
    logic [7:0]       w_ch;
    t_kind            w_kind;
    logic             w_out_free;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // Hold the accepted byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rx <= i_rx_byte;
        end
    end

    // Classify the held byte against the current line
    assign w_eff_cap  = (r_cap > CAP_MAX) ? CAP_MAX : r_cap;
    assign w_fill_inc = {1'b0, r_fill} + 1'b1;
    assign w_ch       = (r_rx == CH_CR) ? CH_LF : r_rx;

    always_comb begin
        case (w_ch)
            CH_BS, CH_DEL: w_kind = (r_fill != '0) ? K_ERASE : K_NONE;
            CH_NAK:        w_kind = (r_fill != '0) ? K_KILL : K_NONE;
            CH_LF:         w_kind = K_NEWLINE;
            CH_TAB:        w_kind = K_NONE;
            default:       w_kind = (w_fill_inc < w_eff_cap) ? K_STORE : K_NONE;
        endcase
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat.kind     = w_kind;
        o_stat.out_free = w_out_free;
        o_stat.fill_one = (r_fill == CNT_W'(1));
        o_stat.fill     = r_fill;
    end

    // Form the result and the fill count it leaves
    // packing: line_length, line_done, write_byte, write_index, write_enable, echo_byte
    always_comb begin
        n_fill     = r_fill;
        n_out_data = '0;
        case (i_cmd.sel)
            SEL_CHAR: begin
                n_out_data = {4'd0, 1'b0, w_ch, r_fill, 1'b1, w_ch};
                n_fill     = w_fill_inc[CNT_W-1:0];
            end
            SEL_CR:  n_out_data = {4'd0, 1'b0, 8'd0, 4'd0, 1'b0, CH_CR};
            SEL_LF: begin
                n_out_data = {r_fill, 1'b1, 8'd0, r_fill, 1'b1, CH_LF};
                n_fill     = '0;
            end
            SEL_BS1: n_out_data = {4'd0, 1'b0, 8'd0, 4'd0, 1'b0, CH_BS};
            SEL_SP:  n_out_data = {4'd0, 1'b0, 8'd0, 4'd0, 1'b0, CH_SP};
            SEL_BS2: begin
                n_out_data = {4'd0, 1'b0, 8'd0, 4'd0, 1'b0, CH_BS};
                n_fill     = r_fill - 1'b1;
            end
            default: n_out_data = '0;
        endcase
    end

    // Fill count advances only when a result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.load) begin
            r_fill <= n_fill;
        end
    end

    // Output register: load on a free slot, drop valid after transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_data <= n_out_data;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule

// File: hdl/console_line_editor_top.sv
// ----------------------------------------------------------------------------
// console_line_editor_top
// Line editor for received console bytes: stores, erases and completes lines
// and emits echo and line-store write results.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries received bytes in; m_* carries results out, one per transfer,
//   with m_tlast on the final result caused by a byte. A byte that causes no
//   result (tab, full line, erase on an empty line) produces no transfer.
//   cfg_* writes line_capacity; write it only while the block is idle.
// Timing:
//   A byte is taken in idle, classified in the next cycle, then one result
//   is loaded per cycle while the output register is free. An ordinary byte
//   gives one result, a newline two, an erase three, a line kill three per character.
//   The controller handles one byte at a time; s_tready is high only in idle.
// Reset:
//   Synchronous, active low: fill count to zero, capacity to 16, no result
//   pending.
// Stall:
//   When m_tready is low the held result stays and the sequencer waits;
//   s_tready stays low until all results of the current byte are loaded.
// ----------------------------------------------------------------------------
module console_line_editor_top #(
    parameter int unsigned LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cle_pkg::CAP_W-1:0]           cfg_data,   // line_capacity
    // Received bytes
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,    // rx_byte
    // Results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // echo_byte[7:0], write_enable[8], write_index[12:9], write_byte[20:13],
    // line_done[21], line_length[25:22], zero fill above
    output logic [cle_pkg::TDATA_W-1:0]         m_tdata,
    output logic                                m_tlast
);
    import cle_pkg::*;

    t_cmd             w_cmd;
    t_stat            w_stat;
    logic [RES_W-1:0] w_res;

    assign cfg_ready = 1'b1;

    cle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    cle_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_valid),
        .i_cfg_data  (cfg_data),
        .i_rx_byte   (s_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .o_out_data  (w_res),
        .o_out_last  (m_tlast)
    );

    assign m_tdata = {{(TDATA_W - RES_W){1'b0}}, w_res};

    // A result is loaded only into a free output slot
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> w_stat.out_free)
        else $error("result loaded over a pending result");

    // A completed line restarts the count at zero
    a_newline_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load && w_cmd.sel == SEL_LF) |=> (w_stat.fill == '0))
        else $error("fill count not cleared after newline");

    // Each erase removes exactly one character
    a_erase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load && w_cmd.sel == SEL_BS2)
            |=> (w_stat.fill == $past(w_stat.fill) - 1'b1))
        else $error("erase did not step the fill count down by one");

    // An accepted byte takes the controller out of idle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a byte is in progress");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for console_line_editor_top. Received bytes go in on the
// s_* stream and are folded into a line-editing predictor (store, erase, line
// kill, newline, capacity limit). Every result transfer on m_* is compared
// field by field against the oldest predicted result. The run walks through
// several line capacities, random idle bursts on both sides and one long
// receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cle_pkg::*;

    localparam int unsigned STORE_DEPTH = LINE_DEPTH_DEF;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          PHASE_ITEMS = 26;
    localparam int          HOLD_START  = 120;
    localparam int          HOLD_CYCLES = 400;
    localparam int          PRINT_CAP   = 40;

    // One result transfer, unpacked
    typedef struct {
        logic [7:0] echo;
        logic       wr_en;
        logic [3:0] wr_idx;
        logic [7:0] wr_byte;
        logic       done;
        logic [3:0] len;
        logic       last;
    } t_editor_result;

    // ------------------------------------------------------------------------
    // Line editor predictor and result store
    // ------------------------------------------------------------------------
    class t_echo_tracker;
        t_editor_result line_echoes[$];
        logic [3:0]     line_fill;
        logic [4:0]     line_cap;
        int             n_errors;

        function new();
            line_fill = '0;
            line_cap  = CAP_RESET;
            n_errors  = 0;
        endfunction

        function int pending();
            return line_echoes.size();
        endfunction

        function void set_capacity(logic [4:0] cap);
            line_cap = cap;
        endfunction

        function void push(logic [7:0] echo, logic wr_en, logic [3:0] wr_idx,
                           logic [7:0] wr_byte, logic done, logic [3:0] len);
            t_editor_result r;
            r.echo    = echo;
            r.wr_en   = wr_en;
            r.wr_idx  = wr_idx;
            r.wr_byte = wr_byte;
            r.done    = done;
            r.len     = len;
            r.last    = 1'b0;
            line_echoes.push_back(r);
        endfunction

        // Echo BS SP BS and drop one character
        function void erase_char();
            push(CH_BS, 1'b0, '0, '0, 1'b0, '0);
            push(CH_SP, 1'b0, '0, '0, 1'b0, '0);
            push(CH_BS, 1'b0, '0, '0, 1'b0, '0);
            line_fill = line_fill - 4'd1;
        endfunction

        // Predict the results of one accepted byte
        function void note_rx_byte(logic [7:0] rx);
            logic [7:0]  c;
            logic [3:0]  cnt;
            int unsigned cap;
            int          n_before;
            c        = (rx == CH_CR) ? CH_LF : rx;
            cnt      = line_fill;
            n_before = line_echoes.size();
            cap      = line_cap;
            if (cap > STORE_DEPTH) cap = STORE_DEPTH;
            if (cap > 16) cap = 16;
            case (c)
                CH_BS, CH_DEL: begin
                    if (line_fill != 0) erase_char();
                end
                CH_NAK: begin
                    while (line_fill != 0) erase_char();
                end
                CH_LF: begin
                    push(CH_CR, 1'b0, '0, '0, 1'b0, '0);
                    push(CH_LF, 1'b1, cnt, 8'h00, 1'b1, cnt);
                    line_fill = '0;
                end
                CH_TAB: begin
                end
                default: begin
                    // Full line: drop silently
                    if (int'(cnt) + 1 < int'(cap)) begin
                        push(c, 1'b1, cnt, c, 1'b0, '0);
                        line_fill = line_fill + 4'd1;
                    end
                end
            endcase
            if (line_echoes.size() > n_before) line_echoes[$].last = 1'b1;
        endfunction

        task report(string what, int unsigned exp, int unsigned got);
            if (n_errors < PRINT_CAP)
                $display("%0t ERROR %s: expected 0x%0h, got 0x%0h", $time, what, exp, got);
            n_errors++;
        endtask

        // Compare one result transfer with the oldest prediction
        task check_echo(logic [TDATA_W-1:0] data, logic tlast);
            t_editor_result exp;
            if (line_echoes.size() == 0) begin
                report("result with none pending", 0, data);
                return;
            end
            exp = line_echoes.pop_front();
            if (data[7:0] !== exp.echo)      report("echo_byte", exp.echo, data[7:0]);
            if (data[8] !== exp.wr_en)       report("write_enable", exp.wr_en, data[8]);
            if (data[12:9] !== exp.wr_idx)   report("write_index", exp.wr_idx, data[12:9]);
            if (data[20:13] !== exp.wr_byte) report("write_byte", exp.wr_byte, data[20:13]);
            if (data[21] !== exp.done)       report("line_done", exp.done, data[21]);
            if (data[25:22] !== exp.len)     report("line_length", exp.len, data[25:22]);
            if (data[TDATA_W-1:RES_W] !== '0)
                report("tdata fill", 0, data[TDATA_W-1:RES_W]);
            if (tlast !== exp.last)          report("tlast", exp.last, tlast);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tlast;

    logic                 gaps_on    = 1'b1;
    logic                 rx_idle_on = 1'b1;
    logic                 rx_hold    = 1'b0;
    int                   rx_stall_left = 0;
    int                   items_sent    = 0;
    int                   cycle_count   = 0;

    t_echo_tracker echoes = new();

    console_line_editor_top #(
        .LINE_DEPTH (STORE_DEPTH)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Offer one byte, hold it until the transfer, then note it
    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        echoes.note_rx_byte(b);
        items_sent++;
    endtask

    // Wait for all results, let a dropped byte finish, then write capacity
    task automatic settle_and_configure(input logic [CAP_W-1:0] cap);
        while (echoes.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        echoes.set_capacity(cap);
    endtask

    // Pick a byte that the editor stores when the line has room
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do begin
            b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(8'h21, 8'h7e));
        end while (b == CH_BS || b == CH_TAB || b == CH_LF || b == CH_CR ||
                   b == CH_NAK || b == CH_DEL);
        return b;
    endfunction

    // Send one edited line, or a short burst of raw noise
    task automatic send_line();
        int n_chars;
        int r;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            return;
        end
        n_chars = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 18)
                                              : $urandom_range(0, 8);
        repeat (n_chars) begin
            r = $urandom_range(0, 99);
            if (r < 8)       send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
            else if (r < 10) send_byte(CH_TAB);
            else             send_byte(plain_byte());
        end
        // Kill the line now and then
        if ($urandom_range(0, 6) == 0) send_byte(CH_NAK);
        send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: check transfers, stall in random bursts
    // ------------------------------------------------------------------------
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (m_tvalid && m_tready) echoes.check_echo(m_tdata, m_tlast);
            if (rx_stall_left > 0)
                rx_stall_left--;
            else if (rx_idle_on && $urandom_range(0, 4) == 0)
                rx_stall_left = $urandom_range(1, 13);
            m_tready <= !rx_hold && rx_stall_left == 0;
        end
    end

    // Hold the receiver off once so the block backs up into its input
    initial begin
        while (items_sent < HOLD_START) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Guard against a hang
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("console_line_editor_top: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0]       directed[$];
        logic [CAP_W-1:0] caps[$];
        int               start;

        // Erases and tab on an empty line, empty newline, byte extremes,
        // single erases, line kill, final newline
        directed = '{CH_BS, CH_DEL, CH_NAK, CH_TAB, CH_CR,
                     8'h00, 8'hff, 8'h80, 8'h7e, 8'h41, CH_DEL, CH_BS,
                     8'h55, 8'haa, CH_NAK, CH_TAB, 8'h31, CH_LF};
        caps = '{5'd31, 5'd0, 5'd1, 5'd2, 5'd5, 5'd17, 5'd16, 5'd9, 5'd16};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset capacity
        foreach (directed[i]) send_byte(directed[i]);
        s_tvalid <= 1'b0;

        // Random lines, one capacity per phase; no idling in phase 3 and the last two phases
        foreach (caps[p]) begin
            settle_and_configure(caps[p]);
            gaps_on    = (p != 3) && (p < caps.size() - 2);
            rx_idle_on <= (p != 3) && (p < caps.size() - 2);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) send_line();
            s_tvalid <= 1'b0;
        end

        // Drain and let any stray result show up
        while (echoes.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (echoes.n_errors == 0)
            $display("console_line_editor_top: match");
        else
            $display("console_line_editor_top: mismatch");
        $finish;
    end

endmodule
